// ----- sv/u8dw_pkg.sv -----
// Package for the UTF-8 display width counter: sequence length codes,
// column counts and the code point checks. No dependencies.
`default_nettype none

package u8dw_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned CpWidth    = 21;
   localparam int unsigned SumWidth   = 16;
   localparam int unsigned LenWidth   = 3;
   localparam int unsigned SeenWidth  = 2;
   localparam int unsigned AddWidth   = 5;

   // Sequence length codes (bytes in the pending sequence).
   localparam logic [LenWidth-1:0] LEN_NONE  = 3'd0;
   localparam logic [LenWidth-1:0] LEN_TWO   = 3'd2;
   localparam logic [LenWidth-1:0] LEN_THREE = 3'd3;
   localparam logic [LenWidth-1:0] LEN_FOUR  = 3'd4;

   localparam logic [1:0] COLS_ZERO   = 2'd0;
   localparam logic [1:0] COLS_ONE    = 2'd1;
   localparam logic [1:0] COLS_TWO    = 2'd2;
   localparam logic [1:0] COLS_REJECT = 2'd2;

   localparam logic [SumWidth-1:0] SUM_MAX  = 16'hFFFF;
   localparam logic [CpWidth-1:0]  CP_MAX   = 21'h10FFFF;
   localparam logic [CpWidth-1:0]  SURR_LO  = 21'h00D800;
   localparam logic [CpWidth-1:0]  SURR_HI  = 21'h00DFFF;
   localparam logic [CpWidth-1:0]  MIN_TWO   = 21'h000080;
   localparam logic [CpWidth-1:0]  MIN_THREE = 21'h000800;
   localparam logic [CpWidth-1:0]  MIN_FOUR  = 21'h010000;

   // Display columns of one decoded character.
   function automatic logic [1:0] char_cols(input logic [CpWidth-1:0] cp);
      logic [1:0] cols;
      if (cp < 21'h20 || cp == 21'h7F || cp inside {[21'h80 : 21'h9F]}) begin
         cols = COLS_TWO;
      end else if (cp inside {[21'h0300 : 21'h036F], [21'h1AB0 : 21'h1AFF],
                              [21'h1DC0 : 21'h1DFF], [21'h20D0 : 21'h20FF],
                              [21'hFE20 : 21'hFE2F], [21'h200B : 21'h200D],
                              21'h00AD, 21'hFEFF}) begin
         cols = COLS_ZERO;
      end else if (cp inside {[21'h4E00 : 21'h9FFF], [21'h3400 : 21'h4DBF],
                              [21'hF900 : 21'hFAFF], [21'h20000 : 21'h3FFFF],
                              [21'hAC00 : 21'hD7AF], [21'h1100 : 21'h115F],
                              [21'h2329 : 21'h232A], [21'hFF01 : 21'hFF60],
                              [21'hFFE0 : 21'hFFE6], [21'h2E80 : 21'h303E],
                              [21'h3190 : 21'h31BF], [21'h31F0 : 21'h31FF],
                              [21'h3200 : 21'h33FF], [21'hA000 : 21'hA4CF],
                              [21'hFE30 : 21'hFE4F]}) begin
         cols = COLS_TWO;
      end else begin
         cols = COLS_ONE;
      end
      return cols;
   endfunction

   // Rejects overlong forms, surrogates and values past the last code point.
   function automatic logic value_ok(input logic [LenWidth-1:0] len,
                                     input logic [CpWidth-1:0]  v);
      logic ok;
      ok = 1'b1;
      if (len == LEN_TWO && v < MIN_TWO)
         ok = 1'b0;
      if (len == LEN_THREE && v < MIN_THREE)
         ok = 1'b0;
      if (len == LEN_FOUR && v < MIN_FOUR)
         ok = 1'b0;
      if (v >= SURR_LO && v <= SURR_HI)
         ok = 1'b0;
      if (v > CP_MAX)
         ok = 1'b0;
      return ok;
   endfunction

endpackage

`default_nettype wire

// ----- sv/u8dw_if.sv -----
// Valid/ready channel interfaces for the UTF-8 display width counter.
// Depends on u8dw_pkg for field widths.
`default_nettype none

interface u8dw_req_if;
   logic                               valid;
   logic                               ready;
   logic [u8dw_pkg::ByteWidth-1:0]     text_byte;
   logic                               end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface u8dw_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [u8dw_pkg::SumWidth-1:0]      column_total;

   modport source (output valid, output column_total, input ready);
   modport sink   (input valid, input column_total, output ready);
endinterface

`default_nettype wire

// ----- sv/utf8_display_width_counter.sv -----
// UTF-8 display width counter, top level. Uses u8dw_pkg and u8dw_if.
// An end-marked req beat passes the input register and then the output register before its rsp beat.
// Throughput: one byte per cycle, unless stalled as below; each byte is held in the input register
// while decode, width lookup and the saturating add run into the state registers.
// A result waiting in the output register stalls input only at the next end byte.
// Reset (synchronous) empties both registers and clears decode state and sum.
`default_nettype none

module utf8_display_width_counter (
   input  wire logic   clock,
   input  wire logic   reset,
   u8dw_req_if.sink    req_if,
   u8dw_rsp_if.source  rsp_if
);
   import u8dw_pkg::*;

   logic                  in_valid_ff;
   logic [ByteWidth-1:0]  in_byte_ff;
   logic                  in_end_ff;

   logic [LenWidth-1:0]   exp_len_ff, exp_len_in;
   logic [SeenWidth-1:0]  seen_ff, seen_in;
   logic [CpWidth-1:0]    value_ff, value_in;
   logic [SumWidth-1:0]   sum_ff, sum_in;

   logic                  out_valid_ff;
   logic [SumWidth-1:0]   out_total_ff;

   logic                  proc;

   // Input register drains unless its end byte would overwrite a waiting result.
   assign proc = in_valid_ff && (!in_end_ff || !out_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || proc;

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.column_total = out_total_ff;

   always_comb begin
      logic                 pend;
      logic                 is_cont;
      logic                 consumed;
      logic [CpWidth-1:0]   cp_new;
      logic [LenWidth-1:0]  seen_next;
      logic [AddWidth-1:0]  add;
      logic [SumWidth:0]    total;
      logic [LenWidth-1:0]  len;
      logic [SeenWidth-1:0] seen;
      logic [CpWidth-1:0]   val;

      pend      = exp_len_ff != LEN_NONE;
      is_cont   = in_byte_ff[7:6] == 2'b10;
      consumed  = 1'b0;
      cp_new    = {value_ff[CpWidth-7:0], in_byte_ff[5:0]};
      seen_next = {1'b0, seen_ff} + 3'd1;
      add       = '0;
      len       = LEN_NONE;
      seen      = '0;
      val       = '0;

      if (pend) begin
         if (is_cont) begin
            consumed = 1'b1;
            if (seen_next + 3'd1 >= exp_len_ff) begin
               if (value_ok(exp_len_ff, cp_new))
                  add = {3'd0, char_cols(cp_new)};
               else
                  add = {1'b0, exp_len_ff, 1'b0};
            end else begin
               len  = exp_len_ff;
               seen = seen_next[SeenWidth-1:0];
               val  = cp_new;
            end
         end else begin
            // broken sequence: 2 columns per byte taken, this byte starts over
            add = {1'b0, seen_next, 1'b0};
         end
      end

      if (!consumed) begin
         if (!in_byte_ff[7]) begin
            add = add + {3'd0, char_cols({13'd0, in_byte_ff})};
         end else if (in_byte_ff[7:5] == 3'b110) begin
            len = LEN_TWO;
            val = {16'd0, in_byte_ff[4:0]};
         end else if (in_byte_ff[7:4] == 4'b1110) begin
            len = LEN_THREE;
            val = {17'd0, in_byte_ff[3:0]};
         end else if (in_byte_ff[7:3] == 5'b11110) begin
            len = LEN_FOUR;
            val = {18'd0, in_byte_ff[2:0]};
         end else begin
            add = add + {3'd0, COLS_REJECT};
         end
      end

      // incomplete tail at the end of the text
      if (in_end_ff && len != LEN_NONE)
         add = add + {1'b0, ({1'b0, seen} + 3'd1), 1'b0};

      total  = {1'b0, sum_ff} + {{(SumWidth+1-AddWidth){1'b0}}, add};
      sum_in = total[SumWidth] ? SUM_MAX : total[SumWidth-1:0];

      exp_len_in = len;
      seen_in    = seen;
      value_in   = val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         exp_len_ff   <= LEN_NONE;
         seen_ff      <= '0;
         value_ff     <= '0;
         sum_ff       <= '0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            in_valid_ff <= 1'b1;
            in_byte_ff  <= req_if.text_byte;
            in_end_ff   <= req_if.end_of_text;
         end else if (proc) begin
            in_valid_ff <= 1'b0;
         end

         if (proc) begin
            if (in_end_ff) begin
               exp_len_ff <= LEN_NONE;
               seen_ff    <= '0;
               value_ff   <= '0;
               sum_ff     <= '0;
            end else begin
               exp_len_ff <= exp_len_in;
               seen_ff    <= seen_in;
               value_ff   <= value_in;
               sum_ff     <= sum_in;
            end
         end

         if (proc && in_end_ff) begin
            out_valid_ff <= 1'b1;
            out_total_ff <= sum_in;
         end else if (rsp_if.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

`ifndef SYNTHESIS
   a_len_code: assert property (@(posedge clock) disable iff (reset)
      exp_len_ff == LEN_NONE || exp_len_ff == LEN_TWO ||
      exp_len_ff == LEN_THREE || exp_len_ff == LEN_FOUR)
      else $error("pending sequence length out of range");

   a_seen_below_len: assert property (@(posedge clock) disable iff (reset)
      exp_len_ff != LEN_NONE |-> ({1'b0, seen_ff} + 3'd2 <= exp_len_ff))
      else $error("continuation count reached sequence length");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      proc && in_end_ff |=> exp_len_ff == LEN_NONE && sum_ff == '0 && out_valid_ff)
      else $error("end byte did not clear state and post a result");

   a_no_result_lost: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_if.ready |-> !(proc && in_end_ff))
      else $error("waiting result overwritten");
`endif

endmodule

`default_nettype wire
